FILE: hw/rtl/vfc_pkg.sv
`default_nettype none

package vfc_pkg;

  // Grid and field sizes
  localparam int GRID_SIZE_DEF = 16;
  localparam int COORD_W       = 4;
  localparam int VOX_W         = 2;
  localparam int REQ_W         = 2;
  localparam int FACE_W        = 3;
  localparam int COUNT_W       = 13;
  localparam int IDX_W         = 15;
  localparam int NUM_FACES     = 6;

  // Saturation point of the block count: base + 7 still fits in IDX_W bits
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd4095;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MESH    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  // Voxel types
  localparam logic [VOX_W-1:0] VOX_AIR   = 2'd0;
  localparam logic [VOX_W-1:0] VOX_DIRT  = 2'd1;
  localparam logic [VOX_W-1:0] VOX_GRASS = 2'd2;
  localparam logic [VOX_W-1:0] VOX_STONE = 2'd3;

  // Corner offsets of a face's two triangles, element 0 is index_a
  function automatic logic [5:0][2:0] face_corners(input logic [FACE_W-1:0] face);
    logic [5:0][2:0] c;
    unique case (face)
      3'd0:    c = {3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0};
      3'd1:    c = {3'd4, 3'd7, 3'd5, 3'd7, 3'd6, 3'd5};
      3'd2:    c = {3'd7, 3'd4, 3'd3, 3'd4, 3'd0, 3'd3};
      3'd3:    c = {3'd6, 3'd2, 3'd1, 3'd5, 3'd6, 3'd1};
      3'd4:    c = {3'd5, 3'd1, 3'd4, 3'd1, 3'd0, 3'd4};
      3'd5:    c = {3'd3, 3'd2, 3'd6, 3'd7, 3'd3, 3'd6};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vfc_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module vfc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/voxel_face_cull_indexer.sv
`default_nettype none

// Voxel face-culling mesh indexer. Holds a GRID_SIZE^3 grid of 2-bit voxel types in one
// RAM and a 13-bit count of meshed blocks. After reset the block runs a clearing pass over
// all GRID_SIZE^3 addresses (4096 at the default size) that sets every voxel to air;
// in_stall_o stays high during it. Write and restart beats are done in the idle state. A
// mesh beat gives 1 to 6 result beats: the seven voxel reads (cell and six neighbors) go
// one per cycle through the single registered RAM read port, then one result beat is
// loaded per cycle into the output register, as fast as the output side takes them.
// Results are sent in face order -z, +z, -x, +x, -y, +y and the final one carries last_o.
// A new beat is taken as soon as the last result of the previous one sits in the output
// register.
module voxel_face_cull_indexer #(
  parameter int GRID_SIZE = vfc_pkg::GRID_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [vfc_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   cell_x_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   cell_y_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   cell_z_i,
  input  wire logic [vfc_pkg::VOX_W-1:0]     voxel_type_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               rendered_o,
  output logic                               face_valid_o,
  output logic      [vfc_pkg::FACE_W-1:0]    face_code_o,
  output logic      [vfc_pkg::IDX_W-1:0]     index_a_o,
  output logic      [vfc_pkg::IDX_W-1:0]     index_b_o,
  output logic      [vfc_pkg::IDX_W-1:0]     index_c_o,
  output logic      [vfc_pkg::IDX_W-1:0]     index_d_o,
  output logic      [vfc_pkg::IDX_W-1:0]     index_e_o,
  output logic      [vfc_pkg::IDX_W-1:0]     index_f_o,
  output logic                               overflow_o,
  output logic                               last_o
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]    G_A     = AW'(GRID_SIZE);
  localparam logic [AW-1:0]    GG_A    = AW'(GRID_SIZE * GRID_SIZE);
  localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);
  localparam logic signed [6:0] G_S    = 7'(GRID_SIZE);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EMIT} state_e;

  // Linear address of an in-grid cell
  function automatic logic [AW-1:0] cell_addr(input logic signed [6:0] nx,
                                              input logic signed [6:0] ny,
                                              input logic signed [6:0] nz);
    return AW'(nx[4:0]) + G_A * AW'(nz[4:0]) + GG_A * AW'(ny[4:0]);
  endfunction

  function automatic logic in_grid(input logic signed [6:0] nx,
                                   input logic signed [6:0] ny,
                                   input logic signed [6:0] nz);
    return (nx >= 7'sd0) && (nx < G_S) && (ny >= 7'sd0) && (ny < G_S) &&
           (nz >= 7'sd0) && (nz < G_S);
  endfunction

  state_e                          state_q;
  logic [AW-1:0]                   clr_addr_q;
  logic [2:0]                      ridx_q;
  logic                            ing_q;
  logic [vfc_pkg::COORD_W-1:0]     x_q, y_q, z_q;
  logic                            rend_q;
  logic                            ovf_q;
  logic [vfc_pkg::IDX_W-1:0]       base_q;
  logic [vfc_pkg::NUM_FACES-1:0]   air_q;
  logic [vfc_pkg::COUNT_W-1:0]     count_q;

  logic                            out_valid_q, rendered_q, face_valid_q, overflow_q, last_q;
  logic [vfc_pkg::FACE_W-1:0]      face_code_q;
  logic [5:0][vfc_pkg::IDX_W-1:0]  idx_q;

  logic                            in_acc;
  logic                            out_free;
  logic signed [6:0]               wx, wy, wz;
  logic signed [6:0]               nx, ny, nz;
  logic                            n_ing;
  logic [AW-1:0]                   raddr;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [vfc_pkg::VOX_W-1:0]       ram_wdata;
  logic [vfc_pkg::VOX_W-1:0]       rdata;
  logic [vfc_pkg::VOX_W-1:0]       ctr_type;
  logic                            ctr_rend;
  logic [vfc_pkg::FACE_W-1:0]      sel;
  logic [vfc_pkg::NUM_FACES-1:0]   rest;
  logic [5:0][2:0]                 corners;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Write-beat coordinates
  assign wx = $signed({3'b000, cell_x_i});
  assign wy = $signed({3'b000, cell_y_i});
  assign wz = $signed({3'b000, cell_z_i});

  // Neighbor coordinates for the read in flight: 0 is the cell, 1..6 faces in order
  always_comb begin
    nx = $signed({3'b000, x_q});
    ny = $signed({3'b000, y_q});
    nz = $signed({3'b000, z_q});
    unique case (ridx_q)
      3'd1:    nz = nz - 7'sd1;
      3'd2:    nz = nz + 7'sd1;
      3'd3:    nx = nx - 7'sd1;
      3'd4:    nx = nx + 7'sd1;
      3'd5:    ny = ny - 7'sd1;
      3'd6:    ny = ny + 7'sd1;
      default: ;
    endcase
  end

  assign n_ing = in_grid(nx, ny, nz);
  assign raddr = cell_addr(nx, ny, nz);

  // RAM write port: clearing pass or write beat
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = vfc_pkg::VOX_AIR;
    end else begin
      ram_we    = in_acc && (req_type_i == vfc_pkg::REQ_WRITE) && in_grid(wx, wy, wz);
      ram_waddr = cell_addr(wx, wy, wz);
      ram_wdata = voxel_type_i;
    end
  end

  vfc_ram #(
    .WIDTH (vfc_pkg::VOX_W),
    .DEPTH (DEPTH)
  ) u_vox_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Returned type, air outside the grid
  assign ctr_type = ing_q ? rdata : vfc_pkg::VOX_AIR;
  assign ctr_rend = (ctr_type == vfc_pkg::VOX_DIRT) || (ctr_type == vfc_pkg::VOX_GRASS);

  // Lowest visible face still to send
  always_comb begin
    sel = '0;
    for (int f = vfc_pkg::NUM_FACES - 1; f >= 0; f--) begin
      if (air_q[f]) begin
        sel = 3'(f);
      end
    end
  end
  assign rest    = air_q & ~(6'b000001 << sel);
  assign corners = vfc_pkg::face_corners(sel);

  // Sequencer, block count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      ridx_q       <= '0;
      ing_q        <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      z_q          <= '0;
      rend_q       <= 1'b0;
      ovf_q        <= 1'b0;
      base_q       <= '0;
      air_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      rendered_q   <= 1'b0;
      face_valid_q <= 1'b0;
      face_code_q  <= '0;
      idx_q        <= '0;
      overflow_q   <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      // emit state reloads the register itself
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == LAST_A) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            priority case (req_type_i)
              vfc_pkg::REQ_MESH: begin
                x_q     <= cell_x_i;
                y_q     <= cell_y_i;
                z_q     <= cell_z_i;
                ridx_q  <= '0;
                state_q <= S_READ;
              end
              vfc_pkg::REQ_RESTART: count_q <= '0;
              default: ;
            endcase
          end
        end
        S_READ: begin
          ing_q  <= n_ing;
          ridx_q <= ridx_q + 3'd1;
          // data of the previous read arrives now
          if (ridx_q == 3'd1) begin
            rend_q <= ctr_rend;
            if (ctr_rend) begin
              base_q <= vfc_pkg::IDX_W'({count_q, 3'b000});
              ovf_q  <= (count_q == vfc_pkg::COUNT_MAX);
              if (count_q != vfc_pkg::COUNT_MAX) begin
                count_q <= count_q + 13'd1;
              end
            end else begin
              ovf_q <= 1'b0;
            end
          end else if (ridx_q >= 3'd2) begin
            air_q[ridx_q - 3'd2] <= (ctr_type == vfc_pkg::VOX_AIR);
          end
          if (ridx_q == 3'd7) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            rendered_q  <= rend_q;
            overflow_q  <= ovf_q;
            if (!rend_q || (air_q == '0)) begin
              face_valid_q <= 1'b0;
              face_code_q  <= '0;
              idx_q        <= '0;
              last_q       <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              face_valid_q <= 1'b1;
              face_code_q  <= sel;
              for (int j = 0; j < 6; j++) begin
                idx_q[j] <= base_q + vfc_pkg::IDX_W'(corners[j]);
              end
              last_q <= (rest == '0);
              air_q  <= rest;
              if (rest == '0) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rendered_o   = rendered_q;
  assign face_valid_o = face_valid_q;
  assign face_code_o  = face_code_q;
  assign index_a_o    = idx_q[0];
  assign index_b_o    = idx_q[1];
  assign index_c_o    = idx_q[2];
  assign index_d_o    = idx_q[3];
  assign index_e_o    = idx_q[4];
  assign index_f_o    = idx_q[5];
  assign overflow_o   = overflow_q;
  assign last_o       = last_q;

  // Checks
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vfc_pkg::COUNT_MAX)
    else $error("block count above saturation point");

  a_noface_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !face_valid_o |-> last_o)
    else $error("result without a face is not the final beat");

  a_face_rendered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && face_valid_o |-> rendered_o && (face_code_o <= 3'd5))
    else $error("face beat from a cell that is not rendered");

  a_read_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) && (ridx_q == 3'd7) |=> (state_q == S_EMIT))
    else $error("read sequence did not hand over to emit");

endmodule

`default_nettype wire
